/* rtl/lzhr_pkg.sv */
// Package: shared types and constants of the hash-row match finder.
`default_nettype none
package lzhr_pkg;

   localparam logic [31:0] HASH_MULT = 32'd153191;
   localparam logic [16:0] MIN_MATCH = 17'd4;
   localparam logic [16:0] NO_MATCH_LEN = 17'd3;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_FIND = 2'd1;
   localparam logic [1:0] FUNC_SKIP = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_S_X,
      S_HASH_A0,
      S_HASH_A1,
      S_HASH_A2,
      S_HASH_MUL,
      S_HASH_ROW,
      S_F_TRD,
      S_F_TUSE,
      S_W_ADR,
      S_W_USE,
      S_B_ADR,
      S_B_USE,
      S_NEXT,
      S_DONE,
      S_S_TRD,
      S_S_TUSE,
      S_S_NEXT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
      logic   deliver;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       byte_eq;
      logic       k_last;
      logic       in_bound;
      logic       j_zero;
      logic       j_last;
      logic       ins_last;
      logic       clr_done;
      logic       rsp_free;
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] pos;
      logic [7:0]  data_byte;
      logic [16:0] data_end;
      logic [16:0] skip_len;
   } req_payload_type;

endpackage
`default_nettype wire

/* rtl/lzhr_req_if.sv */
// Interface: request channel of the match finder.
`default_nettype none
interface lzhr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] pos;
   logic [7:0]  data_byte;
   logic [16:0] data_end;
   logic [16:0] skip_len;

   modport source (output valid, func, pos, data_byte, data_end, skip_len, input ready);
   modport sink (input valid, func, pos, data_byte, data_end, skip_len, output ready);
endinterface
`default_nettype wire

/* rtl/lzhr_rsp_if.sv */
// Interface: result channel of the match finder.
`default_nettype none
interface lzhr_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] match_len;
   logic [15:0] match_pos;

   modport source (output valid, match_len, match_pos, input ready);
   modport sink (input valid, match_len, match_pos, output ready);
endinterface
`default_nettype wire

/* rtl/lzhr_ctrl.sv */
// Controller: sequencing state machine of the match finder.
`default_nettype none
module lzhr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  lzhr_pkg::status_type status,
   output logic                 req_ready,
   output lzhr_pkg::cmd_type    cmd
);
   import lzhr_pkg::*;

   op_type state_ff;
   op_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.op      = state_ff;
      cmd.accept  = 1'b0;
      cmd.deliver = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.func == FUNC_FIND) state_in = S_HASH_A0;
            else if (status.func == FUNC_SKIP) state_in = S_S_X;
            else state_in = S_IDLE;
         end
         S_S_X:      state_in = S_HASH_A0;
         S_HASH_A0:  state_in = S_HASH_A1;
         S_HASH_A1:  state_in = S_HASH_A2;
         S_HASH_A2:  state_in = S_HASH_MUL;
         S_HASH_MUL: state_in = S_HASH_ROW;
         S_HASH_ROW: begin
            state_in = (status.func == FUNC_FIND) ? S_F_TRD : S_S_TRD;
         end
         S_F_TRD:  state_in = S_F_TUSE;
         S_F_TUSE: state_in = S_W_ADR;
         S_W_ADR:  state_in = S_W_USE;
         S_W_USE: begin
            if (!status.byte_eq) state_in = S_NEXT;
            else if (status.k_last) state_in = S_B_ADR;
            else state_in = S_W_ADR;
         end
         S_B_ADR: begin
            state_in = status.in_bound ? S_B_USE : S_NEXT;
         end
         S_B_USE: begin
            state_in = status.byte_eq ? S_B_ADR : S_NEXT;
         end
         S_NEXT: begin
            state_in = status.j_last ? S_DONE : S_F_TRD;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.deliver = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_S_TRD: begin
            state_in = status.j_zero ? S_S_NEXT : S_S_TUSE;
         end
         S_S_TUSE: state_in = S_S_TRD;
         S_S_NEXT: begin
            state_in = status.ins_last ? S_IDLE : S_S_X;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/lzhr_dpath.sv */
// Datapath: window and hash-table memories, hashing, compare and result register.
`default_nettype none
module lzhr_dpath #(
   parameter int WINDOW_SIZE = 65536,
   parameter int HASH_LOG    = 16,
   parameter int ROW_WIDTH   = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lzhr_pkg::cmd_type         cmd,
   input  lzhr_pkg::req_payload_type req_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [16:0]               rsp_match_len,
   output logic [15:0]               rsp_match_pos,
   output lzhr_pkg::status_type      status
);
   import lzhr_pkg::*;

   localparam int WIN_AW   = $clog2(WINDOW_SIZE);
   localparam int TBL_SIZE = 1 << HASH_LOG;
   localparam int JW       = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
   localparam int SPAN_LOG = $clog2(ROW_WIDTH);
   localparam int CW       = (WIN_AW > HASH_LOG) ? WIN_AW : HASH_LOG;
   localparam logic [HASH_LOG-1:0] ROW_MASK =
      HASH_LOG'(~((32'd1 << SPAN_LOG) - 32'd1));

   logic [7:0]          win_mem [WINDOW_SIZE];
   logic [WIN_AW-1:0]   tbl_mem [TBL_SIZE];

   logic [7:0]          rda_ff, rdb_ff;
   logic [WIN_AW-1:0]   tdata_ff;

   logic [1:0]          func_ff;
   logic [15:0]         pos_ff;
   logic [16:0]         end_ff, slen_ff;
   logic [WIN_AW-1:0]   x_ff, wa_ff, wb_ff, cand_ff, prev_ff, best_ff;
   logic [15:0]         byte01_ff;
   logic [31:0]         prod_ff;
   logic [HASH_LOG-1:0] h_ff;
   logic [JW-1:0]       j_ff;
   logic [1:0]          k_ff, ins_ff;
   logic [16:0]         len_ff, l_ff;
   logic [CW-1:0]       clr_ff;
   logic                rsp_valid_ff;
   logic [16:0]         rsp_len_ff;
   logic [15:0]         rsp_pos_ff;

   logic [WIN_AW-1:0]   wadr_a, wadr_b, x_next, win_waddr;
   logic [7:0]          win_wdata;
   logic                win_we, tbl_we;
   logic [HASH_LOG-1:0] tbl_raddr, tbl_waddr, h_j;
   logic [WIN_AW-1:0]   tbl_wdata;
   logic [31:0]         word, off;
   logic                byte_eq, in_bound, j_zero, exit_b;

   assign byte_eq  = (rda_ff == rdb_ff);
   assign j_zero   = (j_ff == '0);
   assign in_bound = (32'(pos_ff) + 32'(l_ff)) < 32'(end_ff);
   assign word     = {rdb_ff, rda_ff, byte01_ff};
   assign off      = j_zero ? 32'd0 : (32'(len_ff) - 32'd3);
   assign h_j      = HASH_LOG'(h_ff + HASH_LOG'(j_ff));
   assign exit_b   = ((cmd.op == S_B_ADR) && !in_bound) ||
                     ((cmd.op == S_B_USE) && !byte_eq);

   always_comb begin
      case (ins_ff)
         2'd0:    x_next = WIN_AW'(32'(pos_ff) + 32'd1);
         2'd1:    x_next = WIN_AW'(32'(pos_ff) + 32'd2);
         default: x_next = WIN_AW'(32'(pos_ff) + 32'(slen_ff) - 32'd1);
      endcase
   end

   // window read addresses
   always_comb begin
      case (cmd.op)
         S_HASH_A0: begin
            wadr_a = x_ff;
            wadr_b = WIN_AW'(32'(x_ff) + 32'd1);
         end
         S_HASH_A1: begin
            wadr_a = WIN_AW'(32'(x_ff) + 32'd2);
            wadr_b = WIN_AW'(32'(x_ff) + 32'd3);
         end
         S_W_ADR: begin
            wadr_a = WIN_AW'(32'(wa_ff) + 32'(k_ff));
            wadr_b = WIN_AW'(32'(wb_ff) + 32'(k_ff));
         end
         S_B_ADR: begin
            wadr_a = WIN_AW'(32'(pos_ff) + 32'(l_ff));
            wadr_b = WIN_AW'(32'(cand_ff) + 32'(l_ff));
         end
         default: begin
            wadr_a = '0;
            wadr_b = '0;
         end
      endcase
   end

   // window and table write ports and the table read address
   always_comb begin
      win_we    = 1'b0;
      win_waddr = WIN_AW'(req_data.pos);
      win_wdata = req_data.data_byte;
      tbl_we    = 1'b0;
      tbl_waddr = h_j;
      tbl_wdata = prev_ff;
      tbl_raddr = (cmd.op == S_S_TRD) ? HASH_LOG'(h_j - HASH_LOG'(1)) : h_j;
      case (cmd.op)
         S_CLEAR: begin
            win_we    = 1'b1;
            win_waddr = clr_ff[WIN_AW-1:0];
            win_wdata = '0;
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff[HASH_LOG-1:0];
            tbl_wdata = '0;
         end
         S_IDLE: begin
            win_we = cmd.accept && (req_data.func == FUNC_LOAD);
         end
         S_F_TUSE: begin
            tbl_we    = 1'b1;
            tbl_wdata = j_zero ? WIN_AW'(pos_ff) : prev_ff;
         end
         S_S_TRD: begin
            tbl_we    = j_zero;
            tbl_wdata = x_ff;
         end
         S_S_TUSE: begin
            tbl_we    = 1'b1;
            tbl_wdata = tdata_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (win_we) win_mem[win_waddr] <= win_wdata;
      rda_ff <= win_mem[wadr_a];
      rdb_ff <= win_mem[wadr_b];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tdata_ff <= tbl_mem[tbl_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == S_CLEAR) clr_ff <= CW'(clr_ff + CW'(1));
         if (cmd.deliver) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_data.func;
         pos_ff  <= req_data.pos;
         end_ff  <= req_data.data_end;
         slen_ff <= req_data.skip_len;
         x_ff    <= WIN_AW'(req_data.pos);
         ins_ff  <= 2'd0;
         len_ff  <= NO_MATCH_LEN;
         best_ff <= '0;
      end
      if (cmd.deliver) begin
         rsp_len_ff <= len_ff;
         rsp_pos_ff <= (len_ff == NO_MATCH_LEN) ? 16'd0 : 16'(best_ff);
      end
      case (cmd.op)
         S_S_X:      x_ff <= x_next;
         S_HASH_A1:  byte01_ff <= {rdb_ff, rda_ff};
         S_HASH_A2:  prod_ff <= word * HASH_MULT;
         S_HASH_ROW: begin
            h_ff <= prod_ff[31 -: HASH_LOG] & ROW_MASK;
            j_ff <= (func_ff == FUNC_FIND) ? '0 : JW'(ROW_WIDTH - 1);
         end
         S_F_TUSE: begin
            cand_ff <= tdata_ff;
            prev_ff <= tdata_ff;
            wa_ff   <= WIN_AW'(32'(pos_ff) + off);
            wb_ff   <= WIN_AW'(32'(tdata_ff) + off);
            k_ff    <= 2'd0;
         end
         S_W_USE: begin
            k_ff <= k_ff + 2'd1;
            if (byte_eq && (k_ff == 2'd3)) begin
               l_ff <= j_zero ? MIN_MATCH : 17'd0;
               if (j_zero) begin
                  len_ff  <= MIN_MATCH;
                  best_ff <= cand_ff;
               end
            end
         end
         S_B_USE: begin
            if (byte_eq) l_ff <= l_ff + 17'd1;
         end
         S_NEXT:   j_ff <= j_ff + JW'(1);
         S_S_TUSE: j_ff <= j_ff - JW'(1);
         S_S_NEXT: ins_ff <= ins_ff + 2'd1;
         default: ;
      endcase
      // close a byte run: keep it when it beats the best so far
      if (exit_b && (l_ff > len_ff)) begin
         len_ff  <= l_ff;
         best_ff <= cand_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_match_len = rsp_len_ff;
   assign rsp_match_pos = rsp_pos_ff;

   assign status.func     = func_ff;
   assign status.byte_eq  = byte_eq;
   assign status.k_last   = (k_ff == 2'd3);
   assign status.in_bound = in_bound;
   assign status.j_zero   = j_zero;
   assign status.j_last   = (j_ff == JW'(ROW_WIDTH - 1));
   assign status.ins_last = (ins_ff == 2'd2);
   assign status.clr_done = (clr_ff == '1);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

/* rtl/lz77_hash_row_match_finder_core.sv */
// Top level: LZ77 match finder with a row-organised hash table.
// The block holds a byte window and a hash table of window positions grouped
// in rows. A load transfer writes one window byte. A find transfer hashes the
// word at pos, walks the row one entry at a time, checks each candidate word
// one byte pair at a time and extends a hit one byte at a time; it returns one
// result transfer. A skip transfer inserts three positions, each costing a
// hash and a shift of the row entries. The window memory gives a single
// byte-pair read per cycle. After reset the block sweeps both memories to
// zero, one entry per cycle, and accepts nothing until that pass ends.
// WINDOW_SIZE must be a power of two. A finished result waits in the output
// register while the next request is taken.
`default_nettype none
module lz77_hash_row_match_finder_core #(
   parameter int WINDOW_SIZE = 65536,
   parameter int HASH_LOG    = 16,
   parameter int ROW_WIDTH   = 4
) (
   input  logic       clock,
   input  logic       reset,
   lzhr_req_if.sink   req_bus,
   lzhr_rsp_if.source rsp_bus
);
   import lzhr_pkg::*;

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_data;
   logic            req_ready;

   // gather the request payload for the datapath
   assign req_data.func      = req_bus.func;
   assign req_data.pos       = req_bus.pos;
   assign req_data.data_byte = req_bus.data_byte;
   assign req_data.data_end  = req_bus.data_end;
   assign req_data.skip_len  = req_bus.skip_len;
   assign req_bus.ready      = req_ready;

   lzhr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   lzhr_dpath #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .HASH_LOG    (HASH_LOG),
      .ROW_WIDTH   (ROW_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data      (req_data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_match_len (rsp_bus.match_len),
      .rsp_match_pos (rsp_bus.match_pos),
      .status        (status)
   );

`ifndef NO_ASSERTIONS
   // no request transfer while the clearing pass runs
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == S_CLEAR) |-> !req_bus.ready)
      else $error("request taken during clearing pass");

   // a result is loaded only when the output register is free
   a_deliver_free: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result overwrote a pending transfer");

   // every accepted request is dispatched next
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (cmd.op == S_DISPATCH))
      else $error("accepted request not dispatched");
`endif

endmodule
`default_nettype wire

/* dv/lz77_hash_row_match_finder_core_tb.sv */
// Testbench: self-checking random and directed test of the hash-row match finder.
`timescale 1ns / 100ps
`default_nettype none
module lz77_hash_row_match_finder_core_tb;
   import lzhr_pkg::*;

   localparam int WIN_SIZE   = 65536;
   localparam int HASH_BITS  = 16;
   localparam int ROW_SLOTS  = 4;
   localparam int TBL_SIZE   = 1 << HASH_BITS;
   localparam int RAND_ITEMS = 400;

   typedef struct {
      logic [16:0] len;
      logic [15:0] pos;
   } match_type;

   // Scoreboard: keeps its own window and hash rows and predicts each match.
   class match_scoreboard;
      bit [7:0]  win_mem[WIN_SIZE];
      bit [15:0] row_mem[TBL_SIZE];
      match_type pending_matches[$];
      int        errors;

      function bit [7:0] byte_at(int unsigned x);
         return win_mem[x % WIN_SIZE];
      endfunction

      function bit [31:0] word_at(int unsigned x);
         return {byte_at(x + 3), byte_at(x + 2), byte_at(x + 1), byte_at(x)};
      endfunction

      function int unsigned row_base(int unsigned x);
         bit [31:0] prod;
         int unsigned span;
         span = 1;
         while (span < ROW_SLOTS) span = span << 1;
         prod = word_at(x) * HASH_MULT;
         return (prod >> (32 - HASH_BITS)) & ((TBL_SIZE - 1) & ~(span - 1));
      endfunction

      function void insert_pos(int unsigned x);
         int unsigned h;
         x = x % WIN_SIZE;
         h = row_base(x);
         for (int j = ROW_SLOTS - 1; j > 0; j--)
            row_mem[(h + j) % TBL_SIZE] = row_mem[(h + j - 1) % TBL_SIZE];
         row_mem[h] = 16'(x);
      endfunction

      function void note_request(req_payload_type r);
         int unsigned pos, dend, h, len, best, prev, cand, l1, idx;
         match_type m;
         pos = 32'(r.pos);
         dend = 32'(r.data_end);
         case (r.func)
            FUNC_LOAD: win_mem[pos] = r.data_byte;
            FUNC_SKIP: begin
               insert_pos(pos + 1);
               insert_pos(pos + 2);
               insert_pos(pos + 32'(r.skip_len) - 1);
            end
            FUNC_FIND: begin
               h = row_base(pos);
               len = 32'(MIN_MATCH) - 1;
               best = 0;
               prev = 32'(row_mem[h]);
               row_mem[h] = 16'(pos);
               if (word_at(pos) == word_at(prev)) begin
                  len = 32'(MIN_MATCH);
                  while (pos + len < dend && byte_at(pos + len) == byte_at(prev + len))
                     len++;
                  best = prev;
               end
               for (int j = 1; j < ROW_SLOTS; j++) begin
                  idx = (h + j) % TBL_SIZE;
                  cand = 32'(row_mem[idx]);
                  row_mem[idx] = 16'(prev);
                  if (word_at(pos + len + 1 - MIN_MATCH) == word_at(cand + len + 1 - MIN_MATCH))
                  begin
                     l1 = 0;
                     while (pos + l1 < dend && byte_at(pos + l1) == byte_at(cand + l1))
                        l1++;
                     if (l1 > len) begin
                        len = l1;
                        best = cand;
                     end
                  end
                  prev = cand;
               end
               m.len = 17'(len);
               m.pos = (len == 32'(NO_MATCH_LEN)) ? 16'd0 : best[15:0];
               pending_matches.push_back(m);
            end
            default: ;
         endcase
      endfunction

      function void compare_result(logic [16:0] len, logic [15:0] pos);
         match_type m;
         if (pending_matches.size() == 0) begin
            $display("%0t: unexpected match len=%0d pos=%0d", $time, len, pos);
            errors++;
            return;
         end
         m = pending_matches.pop_front();
         if (len !== m.len) begin
            $display("%0t: match_len expected %0d actual %0d", $time, m.len, len);
            errors++;
         end
         if (pos !== m.pos) begin
            $display("%0t: match_pos expected %0d actual %0d", $time, m.pos, pos);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   lzhr_req_if req();
   lzhr_rsp_if rsp();

   match_scoreboard board;
   int  burst_left;
   int  sent_count;
   bit  hold_request;

   lz77_hash_row_match_finder_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp)
   );

   always #4 clock = ~clock;

   // Offer one item from the falling edge and hold it until the transfer.
   task automatic send_item(logic [1:0] func, logic [15:0] pos, logic [7:0] data_byte,
                            logic [16:0] data_end, logic [16:0] skip_len);
      req_payload_type r;
      r.func = func;
      r.pos = pos;
      r.data_byte = data_byte;
      r.data_end = data_end;
      r.skip_len = skip_len;
      @(negedge clock);
      req.valid = 1'b1;
      req.func = func;
      req.pos = pos;
      req.data_byte = data_byte;
      req.data_end = data_end;
      req.skip_len = skip_len;
      do @(posedge clock); while (!req.ready);
      board.note_request(r);
      sent_count++;
      // Close the burst with a random gap; some bursts run long with no gap.
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         @(negedge clock);
         req.valid = 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
   endtask

   // Receiver: stall on a changing pattern; honour a long hold-off on request.
   initial begin
      int mode_left, mode, hold_left;
      mode_left = 0;
      mode = 0;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 500;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 1'b0;
         end else begin
            case (mode)
               0: rsp.ready = 1'b1;
               1: rsp.ready = 1'($urandom_range(0, 1));
               default: rsp.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         @(posedge clock);
         if (rsp.valid && rsp.ready) board.compare_result(rsp.match_len, rsp.match_pos);
      end
   end

   // Run limit: well beyond the clearing pass plus the slowest stimulus.
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      bit [7:0]  sym_tab[4];
      int        base, n, p, q;
      bit [16:0] dend;
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      hold_request = 1'b0;
      sent_count = 0;
      burst_left = 5;
      req.valid = 1'b0;
      req.func = FUNC_LOAD;
      req.pos = '0;
      req.data_byte = '0;
      req.data_end = '0;
      req.skip_len = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: an alternating string, short data, self match, wrap, odd codes.
      for (int i = 0; i < 8; i++)
         send_item(FUNC_LOAD, 16'(100 + i), (i % 2 == 0) ? 8'hFF : 8'h00 ^ 8'(i),
                   17'd0, 17'd0);
      send_item(FUNC_LOAD, 16'hFFFF, 8'hFF, 17'd0, 17'd0);
      send_item(FUNC_LOAD, 16'h0000, 8'h00, 17'd0, 17'd0);
      send_item(FUNC_FIND, 16'd100, 8'd0, 17'd108, 17'd0);
      send_item(FUNC_FIND, 16'd104, 8'd0, 17'd106, 17'd0);
      send_item(FUNC_FIND, 16'd104, 8'd0, 17'd110, 17'd0);
      send_item(FUNC_FIND, 16'd104, 8'd0, 17'd108, 17'd0);
      send_item(FUNC_FIND, 16'hFFFF, 8'd0, 17'h10000, 17'd0);
      send_item(FUNC_FIND, 16'd0, 8'd0, 17'd0, 17'd0);
      send_item(FUNC_FIND, 16'd65000, 8'd0, 17'h10000, 17'd0);
      send_item(FUNC_SKIP, 16'd100, 8'd0, 17'd0, 17'd0);
      send_item(FUNC_SKIP, 16'hFFFF, 8'd0, 17'd0, 17'h10000);
      send_item(2'd3, 16'hFFFF, 8'hFF, 17'h1FFFF, 17'h1FFFF);
      send_item(FUNC_FIND, 16'd99, 8'd0, 17'd120, 17'd0);

      // Random: load a short string from a small alphabet, then search and skip.
      while (sent_count < RAND_ITEMS + 20) begin
         case ($urandom_range(0, 9))
            0, 1:    base = $urandom_range(65400, 65535);
            2:       base = $urandom_range(0, 65535);
            default: base = $urandom_range(0, 1023);
         endcase
         foreach (sym_tab[k]) sym_tab[k] = 8'($urandom);
         n = $urandom_range(8, 24);
         dend = 17'(base + n);
         for (int i = 0; i < n; i++)
            send_item(FUNC_LOAD, 16'(base + i), sym_tab[$urandom_range(0, 3)],
                      17'($urandom), 17'd0);
         repeat ($urandom_range(3, 8)) begin
            p = base + $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
               0:       send_item(FUNC_SKIP, 16'(p), 8'($urandom), 17'($urandom),
                                  ($urandom_range(0, 15) == 0) ? 17'($urandom)
                                                               : 17'($urandom_range(0, 12)));
               1:       send_item(2'd3, 16'($urandom), 8'($urandom), 17'($urandom),
                                  17'($urandom));
               2: begin
                  q = $urandom_range(0, 65535);
                  send_item(FUNC_FIND, 16'(q), 8'($urandom), 17'(q + $urandom_range(0, 64)),
                            17'($urandom));
               end
               default: send_item(FUNC_FIND, 16'(p), 8'($urandom),
                                  ($urandom_range(0, 3) == 0) ? 17'(p + $urandom_range(0, 6))
                                                              : dend, 17'($urandom));
            endcase
         end
         if (sent_count > 150 && sent_count < 190) hold_request = 1'b1;
         if (sent_count > 250 && sent_count < 290) begin
            // Pause the sender until every pending match has arrived.
            @(negedge clock);
            req.valid = 1'b0;
            while (board.pending_matches.size() != 0) @(posedge clock);
         end
      end

      @(negedge clock);
      req.valid = 1'b0;
      while (board.pending_matches.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
rtl/lzhr_pkg.sv
rtl/lzhr_req_if.sv
rtl/lzhr_rsp_if.sv
rtl/lzhr_ctrl.sv
rtl/lzhr_dpath.sv
rtl/lz77_hash_row_match_finder_core.sv
dv/lz77_hash_row_match_finder_core_tb.sv
